// ----- rtl/sbpp_pkg.sv -----
// Shared types and constants for the stripe/brick pattern pixel core.
// No dependencies; imported by rtl/stripe_brick_pattern_pixel_core.sv.
package sbpp_pkg;

   localparam int COORD_W    = 12;  // pixel coordinate port width
   localparam int CFG_W      = 12;  // offsets, line width, divisors
   localparam int COLOR_W    = 32;  // RGBA, one byte per channel
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      MODE_PLAIN   = 2'd0,
      MODE_HSTRIPE = 2'd1,
      MODE_VSTRIPE = 2'd2,
      MODE_BRICK   = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_MODE     = 3'd0,
      CSR_OFFSET_X         = 3'd1,
      CSR_OFFSET_Y         = 3'd2,
      CSR_LINE_WIDTH       = 3'd3,
      CSR_PERIOD           = 3'd4,
      CSR_HALF_BRICK_WIDTH = 3'd5,
      CSR_FORE_COLOR       = 3'd6,
      CSR_BACK_COLOR       = 3'd7
   } csr_index_type;

endpackage

// ----- rtl/stripe_brick_pattern_pixel_core.sv -----
// Stripe/brick procedural test pattern core: pixel coordinate in, RGBA color out.
// Depends on rtl/sbpp_pkg.sv.
//
// One pixel is taken every clock while busy is low (busy is high only during
// reset). Each color appears on rsp_pixel_color for one cycle with rsp_strobe,
// after its coordinate has passed the input register, the divider stages and
// the color register. The divider stages are the two modulo units: each is a restoring
// divider with one quotient bit per pipeline stage over the COORD_BITS + 1
// bit coordinate sum. Results leave in input order and the receiver cannot
// stall them. Configuration writes take effect at once and are meant for
// times when no pixel is in flight.
module stripe_brick_pattern_pixel_core
   import sbpp_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_W-1:0]    req_pixel_x,
   input  logic [COORD_W-1:0]    req_pixel_y,
   output logic                  rsp_strobe,
   output logic [COLOR_W-1:0]    rsp_pixel_color,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W = COORD_BITS + 1;
   localparam int KEEP  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam logic [COORD_W-1:0] CMASK = COORD_W'((33'(1) << KEEP) - 33'(1));
   localparam int LAT   = SUM_W + 2;

   // ---------------------------------------------------------------- registers
   mode_type             mode_ff, mode_in;
   logic [CFG_W-1:0]     offset_x_ff, offset_x_in;
   logic [CFG_W-1:0]     offset_y_ff, offset_y_in;
   logic [CFG_W-1:0]     line_width_ff, line_width_in;
   logic [CFG_W-1:0]     period_ff, period_in;
   logic [CFG_W-1:0]     half_brick_ff, half_brick_in;
   logic [COLOR_W-1:0]   fore_color_ff, fore_color_in;
   logic [COLOR_W-1:0]   back_color_ff, back_color_in;
   logic [CFG_W-1:0]     wdata12;

   assign wdata12 = csr_wdata[CFG_W-1:0];

   always_comb begin
      mode_in       = mode_ff;
      offset_x_in   = offset_x_ff;
      offset_y_in   = offset_y_ff;
      line_width_in = line_width_ff;
      period_in     = period_ff;
      half_brick_in = half_brick_ff;
      fore_color_in = fore_color_ff;
      back_color_in = back_color_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_MODE:     mode_in       = mode_type'(csr_wdata[1:0]);
            CSR_OFFSET_X:         offset_x_in   = wdata12;
            CSR_OFFSET_Y:         offset_y_in   = wdata12;
            CSR_LINE_WIDTH:       line_width_in = wdata12;
            // floor divisors at one
            CSR_PERIOD:           period_in     = (wdata12 == '0) ? CFG_W'(1) : wdata12;
            CSR_HALF_BRICK_WIDTH: half_brick_in = (wdata12 == '0) ? CFG_W'(1) : wdata12;
            CSR_FORE_COLOR:       fore_color_in = csr_wdata;
            CSR_BACK_COLOR:       back_color_in = csr_wdata;
            default:              mode_in       = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_PLAIN;
         offset_x_ff   <= '0;
         offset_y_ff   <= '0;
         line_width_ff <= CFG_W'(1);
         period_ff     <= CFG_W'(8);
         half_brick_ff <= CFG_W'(8);
         fore_color_ff <= '1;
         back_color_ff <= '0;
      end else begin
         mode_ff       <= mode_in;
         offset_x_ff   <= offset_x_in;
         offset_y_ff   <= offset_y_in;
         line_width_ff <= line_width_in;
         period_ff     <= period_in;
         half_brick_ff <= half_brick_in;
         fore_color_ff <= fore_color_in;
         back_color_ff <= back_color_in;
      end
   end

   // ---------------------------------------------------------- stage 0: sums
   logic             accept;
   logic [SUM_W-1:0] xsum_in, ysum_in;

   assign busy   = reset;
   assign accept = start & ~busy;

   assign xsum_in = SUM_W'(req_pixel_x & CMASK) + SUM_W'(offset_x_ff & CMASK);
   assign ysum_in = SUM_W'(req_pixel_y & CMASK) + SUM_W'(offset_y_ff & CMASK);

   // divider A: row (or column in vertical stripes) by period
   // divider B: column by half brick width
   logic             vld_ff  [0:SUM_W];
   logic [SUM_W-1:0] dva_ff  [0:SUM_W];
   logic [SUM_W-1:0] dvb_ff  [0:SUM_W];
   logic [CFG_W-1:0] rema_ff [1:SUM_W];
   logic [CFG_W-1:0] remb_ff [1:SUM_W];
   logic             qa_ff   [1:SUM_W];
   logic             qb_ff   [1:SUM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
      end
      dva_ff[0] <= (mode_ff == MODE_VSTRIPE) ? xsum_in : ysum_in;
      dvb_ff[0] <= xsum_in;
   end

   // ------------------------------------------- stages 1..SUM_W: one bit each
   for (genvar k = 0; k < SUM_W; k++) begin : g_div
      localparam int BIT = SUM_W - 1 - k;
      logic [CFG_W-1:0] prev_a, prev_b;
      logic [CFG_W:0]   trial_a, trial_b;
      logic [CFG_W+1:0] diff_a, diff_b;
      logic [CFG_W-1:0] rema_in, remb_in;

      if (k == 0) begin : g_first
         assign prev_a = '0;
         assign prev_b = '0;
      end else begin : g_next
         assign prev_a = rema_ff[k];
         assign prev_b = remb_ff[k];
      end

      always_comb begin
         trial_a = {prev_a, dva_ff[k][BIT]};
         trial_b = {prev_b, dvb_ff[k][BIT]};
         diff_a  = {1'b0, trial_a} - {2'b00, period_ff};
         diff_b  = {1'b0, trial_b} - {2'b00, half_brick_ff};
         // keep the trial on borrow, else take the difference
         rema_in = diff_a[CFG_W+1] ? trial_a[CFG_W-1:0] : diff_a[CFG_W-1:0];
         remb_in = diff_b[CFG_W+1] ? trial_b[CFG_W-1:0] : diff_b[CFG_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         dva_ff[k+1]  <= dva_ff[k];
         dvb_ff[k+1]  <= dvb_ff[k];
         rema_ff[k+1] <= rema_in;
         remb_ff[k+1] <= remb_in;
         qa_ff[k+1]   <= ~diff_a[CFG_W+1];
         qb_ff[k+1]   <= ~diff_b[CFG_W+1];
      end
   end

   // ------------------------------------------------ final stage: pick color
   logic               rsp_strobe_ff;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               row_line, col_line;

   assign row_line = rema_ff[SUM_W] < line_width_ff;
   // quotient parity is the last quotient bit
   assign col_line = (qa_ff[SUM_W] == qb_ff[SUM_W]) && (remb_ff[SUM_W] < line_width_ff);

   always_comb begin
      unique case (mode_ff)
         MODE_PLAIN:   color_in = fore_color_ff;
         MODE_HSTRIPE,
         MODE_VSTRIPE: color_in = row_line ? fore_color_ff : back_color_ff;
         MODE_BRICK:   color_in = (row_line || col_line) ? fore_color_ff : back_color_ff;
         default:      color_in = fore_color_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vld_ff[SUM_W];
      end
      color_ff <= color_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_pixel_color = color_ff;

`ifndef SYNTH
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(start && !busy, LAT))
      else $error("result strobe does not follow transaction latency");

   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SUM_W] == $past(start && !busy, SUM_W + 1))
      else $error("divider valid out of step with accepted transactions");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !vld_ff[0] && !vld_ff[SUM_W])
      else $error("pipeline not flushed by reset");
`endif

endmodule
